### rtl/core/cfs_pkg.sv
// Coalescing flush scheduler: shared types and codes.
// Request and result payload structs, action/reason codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_RECORD  = 2'd1;
    localparam logic [1:0] ACT_OUTCOME = 2'd2;

    // flush reasons
    localparam logic [1:0] RSN_CAP    = 2'd0;
    localparam logic [1:0] RSN_QUIET  = 2'd1;
    localparam logic [1:0] RSN_WINDOW = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_QUIET_TICKS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_TICKS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_BACKOFF  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BACKOFF   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY_LIMIT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COIN_CAP      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OPS_THRESHOLD = 3'd6;

    // reset values of the configuration registers
    localparam logic [31:0] RST_QUIET_TICKS   = 32'd2000;
    localparam logic [31:0] RST_WINDOW_TICKS  = 32'd10000;
    localparam logic [31:0] RST_BASE_BACKOFF  = 32'd500;
    localparam logic [31:0] RST_MAX_BACKOFF   = 32'd30000;
    localparam logic [3:0]  RST_RETRY_LIMIT   = 4'd6;
    localparam logic [30:0] RST_COIN_CAP      = 31'd1000;
    localparam logic [15:0] RST_OPS_THRESHOLD = 16'd50;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now;
        logic signed [15:0] coin_change;
        logic [7:0]         op_count;
        logic               flush_ok;
    } in_t;

    typedef struct packed {
        logic               flush_request;
        logic [1:0]         flush_reason;
        logic signed [31:0] coins_pending;
        logic [15:0]        ops_pending;
        logic [3:0]         retries;
        logic               waiting_outcome;
    } out_t;

endpackage

`default_nettype wire

### rtl/core/coalescing_flush_scheduler.sv
// Coalescing flush scheduler top level: decides when pending changes are flushed.
// Input register, one pass of scheduling logic, result register.
// Depends on cfs_pkg.
//
//  port group     | dir | handshake           | payload
//  ---------------+-----+---------------------+------------------
//  s_*  request   | in  | s_valid / s_ready   | cfs_pkg::in_t
//  m_*  result    | out | m_valid / m_ready   | cfs_pkg::out_t
//  cfg_*  config  | in  | cfg_we (no wait)    | cfg_addr, cfg_wdata
//
// One request per cycle sustained while m_ready is high; an accepted request is held in the
// input register, then its result is loaded into the result register.
// All scheduler state updates in the cycle a request moves into the result register.
// A stall on m_ready holds the result; one more request can sit in the input
// register, then s_ready drops.
// aresetn is synchronous, active low; it clears the state and restores the
// default configuration.
`timescale 1ns / 1ps
`default_nettype none

module coalescing_flush_scheduler (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cfs_pkg::in_t                      s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cfs_pkg::out_t                          m_data,
    input  wire logic                              cfg_we,
    input  wire logic [cfs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [cfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // configuration
    logic [31:0] quiet_ticks_reg, window_ticks_reg, base_backoff_reg, max_backoff_reg;
    logic [3:0]  retry_limit_reg;
    logic [30:0] coin_cap_reg;
    logic [15:0] ops_threshold_reg;

    // pipeline
    logic          in_valid_reg, out_valid_reg;
    cfs_pkg::in_t  in_data_reg;
    cfs_pkg::out_t out_data_reg, out_data_next;
    logic          adv;

    // scheduler state
    logic signed [31:0] coin_total_reg, coin_total_next;
    logic [15:0] op_total_reg, op_total_next;
    logic [31:0] window_start_reg, window_start_next;
    logic        window_open_reg, window_open_next;
    logic [31:0] last_change_reg, last_change_next;
    logic [31:0] retry_after_reg, retry_after_next;
    logic [3:0]  retry_count_reg, retry_count_next;
    logic        awaiting_reg, awaiting_next;
    logic [31:0] request_time_reg, request_time_next;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quiet_ticks_reg   <= cfs_pkg::RST_QUIET_TICKS;
            window_ticks_reg  <= cfs_pkg::RST_WINDOW_TICKS;
            base_backoff_reg  <= cfs_pkg::RST_BASE_BACKOFF;
            max_backoff_reg   <= cfs_pkg::RST_MAX_BACKOFF;
            retry_limit_reg   <= cfs_pkg::RST_RETRY_LIMIT;
            coin_cap_reg      <= cfs_pkg::RST_COIN_CAP;
            ops_threshold_reg <= cfs_pkg::RST_OPS_THRESHOLD;
        end else if (cfg_we) begin
            case (cfg_addr)
                cfs_pkg::REG_QUIET_TICKS:   quiet_ticks_reg   <= cfg_wdata;
                cfs_pkg::REG_WINDOW_TICKS:  window_ticks_reg  <= cfg_wdata;
                cfs_pkg::REG_BASE_BACKOFF:  base_backoff_reg  <= cfg_wdata;
                cfs_pkg::REG_MAX_BACKOFF:   max_backoff_reg   <= cfg_wdata;
                cfs_pkg::REG_RETRY_LIMIT:   retry_limit_reg   <= cfg_wdata[3:0];
                cfs_pkg::REG_COIN_CAP:      coin_cap_reg      <= cfg_wdata[30:0];
                cfs_pkg::REG_OPS_THRESHOLD: ops_threshold_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // scheduling logic
    logic signed [32:0] chg_ext, sum, cap_pos, cap_neg, sum_clamped, mag;
    logic [16:0] ops_sum;
    logic [15:0] ops_sat;
    logic [31:0] now;
    logic        backoff_run, may_req, quiet, expired, cap_hit;
    logic [46:0] delay_wide;
    logic [31:0] delay;
    logic [4:0]  rc_inc;
    logic        req;
    logic [1:0]  reason;

    always_comb begin
        now         = in_data_reg.now;
        chg_ext     = 33'(in_data_reg.coin_change);
        sum         = {coin_total_reg[31], coin_total_reg} + chg_ext;
        cap_pos     = $signed({2'b00, coin_cap_reg});
        cap_neg     = -cap_pos;
        sum_clamped = sum;
        if (sum > cap_pos) begin
            sum_clamped = cap_pos;
        end else if (sum < cap_neg) begin
            sum_clamped = cap_neg;
        end
        mag     = sum_clamped[32] ? -sum_clamped : sum_clamped;
        ops_sum = {1'b0, op_total_reg} + {9'd0, in_data_reg.op_count};
        ops_sat = ops_sum[16] ? 16'hFFFF : ops_sum[15:0];

        backoff_run = (now - request_time_reg) < (retry_after_reg - request_time_reg);
        quiet       = (now - last_change_reg) >= quiet_ticks_reg;
        expired     = (now - window_start_reg) >= window_ticks_reg;

        delay_wide = {15'd0, base_backoff_reg} << retry_count_reg;
        delay      = (delay_wide > {15'd0, max_backoff_reg}) ? max_backoff_reg
                                                             : delay_wide[31:0];
        rc_inc     = {1'b0, retry_count_reg} + 5'd1;

        coin_total_next   = coin_total_reg;
        op_total_next     = op_total_reg;
        window_start_next = window_start_reg;
        window_open_next  = window_open_reg;
        last_change_next  = last_change_reg;
        retry_after_next  = retry_after_reg;
        retry_count_next  = retry_count_reg;
        awaiting_next     = awaiting_reg;
        request_time_next = request_time_reg;
        req     = 1'b0;
        reason  = cfs_pkg::RSN_CAP;
        cap_hit = 1'b0;
        may_req = 1'b0;

        case (in_data_reg.action)
            cfs_pkg::ACT_RECORD: begin
                coin_total_next = sum_clamped[31:0];
                op_total_next   = ops_sat;
                if (!window_open_reg) begin
                    window_open_next  = 1'b1;
                    window_start_next = now;
                end
                last_change_next = now;
                // totals checked after this record is applied
                may_req = !awaiting_reg && !backoff_run &&
                          (sum_clamped != '0 || ops_sat != '0);
                cap_hit = (mag >= cap_pos) || (ops_sat >= ops_threshold_reg);
                if (cap_hit && may_req) begin
                    req = 1'b1;
                end
            end
            cfs_pkg::ACT_TICK: begin
                may_req = !awaiting_reg && !backoff_run &&
                          (coin_total_reg != '0 || op_total_reg != '0);
                if (may_req && quiet) begin
                    req    = 1'b1;
                    reason = cfs_pkg::RSN_QUIET;
                end else if (may_req && expired) begin
                    req    = 1'b1;
                    reason = cfs_pkg::RSN_WINDOW;
                end
            end
            cfs_pkg::ACT_OUTCOME: begin
                if (awaiting_reg) begin
                    if (in_data_reg.flush_ok) begin
                        coin_total_next   = '0;
                        op_total_next     = '0;
                        window_start_next = '0;
                        window_open_next  = 1'b0;
                        last_change_next  = '0;
                        retry_after_next  = '0;
                        retry_count_next  = '0;
                        request_time_next = '0;
                    end else begin
                        retry_after_next = request_time_reg + delay;
                        retry_count_next = (rc_inc < {1'b0, retry_limit_reg}) ? rc_inc[3:0]
                                                                             : retry_limit_reg;
                    end
                    awaiting_next = 1'b0;
                end
            end
            default: ;
        endcase

        // the backoff deadline stays put across a new request
        if (req) begin
            awaiting_next     = 1'b1;
            request_time_next = now;
        end

        out_data_next.flush_request   = req;
        out_data_next.flush_reason    = reason;
        out_data_next.coins_pending   = coin_total_next;
        out_data_next.ops_pending     = op_total_next;
        out_data_next.retries         = retry_count_next;
        out_data_next.waiting_outcome = awaiting_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            coin_total_reg   <= '0;
            op_total_reg     <= '0;
            window_start_reg <= '0;
            window_open_reg  <= 1'b0;
            last_change_reg  <= '0;
            retry_after_reg  <= '0;
            retry_count_reg  <= '0;
            awaiting_reg     <= 1'b0;
            request_time_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg    <= 1'b1;
                coin_total_reg   <= coin_total_next;
                op_total_reg     <= op_total_next;
                window_start_reg <= window_start_next;
                window_open_reg  <= window_open_next;
                last_change_reg  <= last_change_next;
                retry_after_reg  <= retry_after_next;
                retry_count_reg  <= retry_count_next;
                awaiting_reg     <= awaiting_next;
                request_time_reg <= request_time_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    // a request always leaves the scheduler waiting for its outcome
    a_req_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.flush_request |-> m_data.waiting_outcome)
        else $error("flush request without waiting_outcome");

    // no request without something pending
    a_req_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.flush_request |->
            (m_data.coins_pending != '0 || m_data.ops_pending != '0))
        else $error("flush request with nothing pending");

    a_reason_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.flush_request |-> m_data.flush_reason == cfs_pkg::RSN_CAP)
        else $error("reason set without a request");

    // no second request while one is outstanding
    a_single_req: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && awaiting_reg |-> !req)
        else $error("request issued while awaiting outcome");

    // the result register mirrors the state it just wrote
    a_state_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (m_data.waiting_outcome == awaiting_reg) &&
                (m_data.retries == retry_count_reg))
        else $error("result out of step with scheduler state");

endmodule

`default_nettype wire
